[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Plain header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");
`endif

[rtl/hrst_pkg.sv]
// Package for the hashed resident set table: payload types, codes, hash mix constants.
// No dependencies.
`default_nettype none
package hrst_pkg;
    localparam int SLOT_BITS_DEF = 12;
    localparam logic [63:0] MIX_MUL = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] MIX_SEED = 64'h8445d61a4e774912;
    localparam int MIX_SHIFT = 47;
    localparam logic [63:0] MIX_H0 = MIX_SEED ^ (MIX_MUL << 3);

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_ADVANCE = 3'd3;
    localparam logic [2:0] REQ_NEXT = 3'd4;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_USED = 2'd1;
    localparam logic [1:0] ST_TOMB = 2'd2;

    localparam logic [1:0] RES_OK = 2'd0;
    localparam logic [1:0] RES_MISS = 2'd1;
    localparam logic [1:0] RES_FULL = 2'd2;

    localparam logic [1:0] ADDR_SIZE = 2'd0;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] key;
        logic [11:0] start_index;
        logic [12:0] batch_count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_key;
        logic [11:0] slot_index;
    } rsp_t;
endpackage
`default_nettype wire

[rtl/hashed_resident_set_table_top.sv]
// The hash runs four 64x64 multiplies, each as two 32x32-wide partial product steps
// plus a post step (an xor-shift after all but the second), then each probed slot takes
// a memory read state and a check state, and a done state presents the result.
// Next-valid requests skip the hash; advance-clock and unknown codes go straight to done.
// One request at a time; the next is taken only after the result beat has been accepted.
// Reset: a clearing pass marks every slot empty; size register resets to 12.
// Top level of the hashed resident set table; uses hrst_pkg.
`default_nettype none
module hashed_resident_set_table_top import hrst_pkg::*; #(
    parameter int SLOT_BITS = SLOT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire req_t        in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output rsp_t             out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int DEPTH = 1 << SLOT_BITS;
    localparam int CW = SLOT_BITS + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_MULH  = 4'd3;
    localparam logic [3:0] S_POST  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [3:0] size_reg;
    logic [SLOT_BITS-1:0] clock_reg;

    // size and mask
    logic [4:0] l_eff;
    logic [SLOT_BITS-1:0] mask;
    always_comb
    begin
        l_eff = {1'b0, size_reg};
        if (size_reg == 4'd0) l_eff = 5'd1;
        if ({27'd0, l_eff} > SLOT_BITS) l_eff = 5'(SLOT_BITS);
        mask = SLOT_BITS'((CW'(1) << l_eff) - CW'(1));
    end

    // APB
    assign pready = 1'b1;
    assign prdata = {28'd0, size_reg};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) size_reg <= 4'd12;
        else if (psel && penable && pwrite && paddr == ADDR_SIZE)
            size_reg <= pwdata[3:0];
    end

    // datapath regs
    req_t req_reg;
    logic [63:0] k_reg, h_reg, lo_reg;
    logic [2:0]  mstep_reg;      // which multiply of four
    logic [SLOT_BITS-1:0] pos_reg;
    logic [CW-1:0] cnt_reg, clr_reg;
    logic have_free_reg;
    logic [SLOT_BITS-1:0] free_reg;
    rsp_t rsp_reg;
    logic out_v_reg;

    // memories
    logic [1:0]  stat_mem [DEPTH];
    logic [63:0] key_mem [DEPTH];
    logic [SLOT_BITS-1:0] raddr;
    logic [1:0]  stat_rd;
    logic [63:0] key_rd;
    logic        swe, kwe;
    logic [SLOT_BITS-1:0] waddr;
    logic [1:0]  swdata;
    always_ff @(posedge clk)
    begin
        if (swe) stat_mem[waddr] <= swdata;
        if (kwe) key_mem[waddr] <= req_reg.key;
        stat_rd <= stat_mem[raddr];
        key_rd <= key_mem[raddr];
    end

    // shared multiply: low 32x32 product first, cross terms added in the second step
    logic [63:0] mop;
    always_comb
    begin
        mop = (mstep_reg < 3'd2) ? k_reg : h_reg;
    end
    logic [63:0] p_lo;
    logic [31:0] p_cross;
    assign p_lo = {32'd0, mop[31:0]} * {32'd0, MIX_MUL[31:0]};
    assign p_cross = mop[63:32] * MIX_MUL[31:0] + mop[31:0] * MIX_MUL[63:32];

    logic [63:0] prod;
    assign prod = lo_reg + {p_cross, 32'd0};

    logic [63:0] h_xs;
    assign h_xs = h_reg ^ (h_reg >> MIX_SHIFT);

    logic acc_in;
    assign acc_in = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || out_v_reg;
    assign out_valid = out_v_reg;
    assign out_data = rsp_reg;

    logic [SLOT_BITS-1:0] pos_inc;
    assign pos_inc = (pos_reg + SLOT_BITS'(1)) & mask;
    logic [CW-1:0] size_cnt;
    assign size_cnt = CW'(1) << l_eff;

    always_comb
    begin
        state_next = state_reg;
        raddr = pos_reg;
        swe = 1'b0;
        kwe = 1'b0;
        waddr = pos_reg;
        swdata = ST_USED;
        case (state_reg)
            S_CLEAR:
            begin
                swe = 1'b1;
                swdata = ST_EMPTY;
                waddr = clr_reg[SLOT_BITS-1:0];
                if (clr_reg == CW'(DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (in_data.req_type == REQ_ADVANCE) state_next = S_DONE;
                    else if (in_data.req_type == REQ_NEXT) state_next = S_RD;
                    else if (in_data.req_type inside {REQ_INSERT, REQ_LOOKUP,
                                                      REQ_REMOVE})
                        state_next = S_MUL;
                    else state_next = S_DONE;
                end
            end
            S_MUL:  state_next = S_MULH;
            S_MULH: state_next = S_POST;
            S_POST: state_next = (mstep_reg == 3'd4) ? S_RD : S_MUL;
            S_RD:   state_next = S_CHK;
            S_CHK:
            begin
                state_next = S_RD;
                if (req_reg.req_type == REQ_INSERT)
                begin
                    if (stat_rd == ST_USED && key_rd == req_reg.key)
                        state_next = S_DONE;
                    else if (stat_rd == ST_EMPTY || cnt_reg == size_cnt - CW'(1))
                    begin
                        state_next = S_DONE;
                        if (stat_rd != ST_USED || have_free_reg)
                        begin
                            swe = 1'b1;
                            kwe = 1'b1;
                            waddr = have_free_reg ? free_reg : pos_reg;
                        end
                    end
                end
                else if (req_reg.req_type == REQ_NEXT)
                begin
                    if (stat_rd == ST_USED || cnt_reg == size_cnt - CW'(1))
                        state_next = S_DONE;
                end
                else
                begin
                    if (stat_rd == ST_EMPTY || cnt_reg == size_cnt - CW'(1))
                        state_next = S_DONE;
                    if (stat_rd == ST_USED && key_rd == req_reg.key)
                    begin
                        state_next = S_DONE;
                        if (req_reg.req_type == REQ_REMOVE)
                        begin
                            swe = 1'b1;
                            swdata = ST_TOMB;
                        end
                    end
                end
                if (state_next == S_RD) raddr = pos_inc;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            clock_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + CW'(1);
            if (out_v_reg && !out_stall) out_v_reg <= 1'b0;
            if (state_reg == S_DONE)
                out_v_reg <= 1'b1;
            if (state_reg == S_IDLE && acc_in && in_data.req_type == REQ_ADVANCE)
                clock_reg <= ((clock_reg & mask) + SLOT_BITS'(in_data.batch_count)) & mask;
        end
    end

    // payload and probe bookkeeping
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    req_reg <= in_data;
                    k_reg <= in_data.key;
                    h_reg <= MIX_H0;
                    mstep_reg <= 3'd0;
                    cnt_reg <= '0;
                    have_free_reg <= 1'b0;
                    pos_reg <= SLOT_BITS'(in_data.start_index) & mask;
                    if (in_data.req_type == REQ_ADVANCE)
                        rsp_reg <= '{status: RES_OK, found_key: 64'd0,
                                     slot_index: 12'(clock_reg & mask)};
                    else if (in_data.req_type == REQ_NEXT)
                        rsp_reg <= '{status: RES_FULL, found_key: 64'd0, slot_index: 12'd0};
                    else
                        rsp_reg <= '{status: RES_MISS, found_key: 64'd0, slot_index: 12'd0};
                end
            end
            S_MUL: lo_reg <= p_lo;
            S_MULH:
            begin
                case (mstep_reg)
                    3'd0: k_reg <= prod;
                    3'd1: h_reg <= h_reg ^ prod;
                    3'd2, 3'd3: h_reg <= prod;
                    default: h_reg <= h_reg;
                endcase
                mstep_reg <= mstep_reg + 3'd1;
            end
            S_POST:
            begin
                case (mstep_reg)
                    3'd1: k_reg <= k_reg ^ (k_reg >> MIX_SHIFT);
                    3'd3: h_reg <= h_xs;
                    3'd4:
                    begin
                        h_reg <= h_xs;
                        pos_reg <= h_xs[SLOT_BITS-1:0] & mask;
                    end
                    default: h_reg <= h_reg;
                endcase
            end
            S_CHK:
            begin
                pos_reg <= pos_inc;
                cnt_reg <= cnt_reg + CW'(1);
                if (req_reg.req_type == REQ_INSERT && stat_rd != ST_USED && !have_free_reg)
                begin
                    have_free_reg <= 1'b1;
                    free_reg <= pos_reg;
                end
                if (state_next == S_DONE)
                begin
                    if (req_reg.req_type == REQ_INSERT)
                    begin
                        if (stat_rd == ST_USED && key_rd == req_reg.key)
                            rsp_reg <= '{status: RES_MISS, found_key: 64'd0,
                                         slot_index: 12'(pos_reg)};
                        else if (have_free_reg)
                            rsp_reg <= '{status: RES_OK, found_key: 64'd0,
                                         slot_index: 12'(free_reg)};
                        else if (stat_rd != ST_USED)
                            rsp_reg <= '{status: RES_OK, found_key: 64'd0,
                                         slot_index: 12'(pos_reg)};
                        else
                            rsp_reg <= '{status: RES_FULL, found_key: 64'd0,
                                         slot_index: 12'd0};
                    end
                    else if (req_reg.req_type == REQ_NEXT)
                    begin
                        if (stat_rd == ST_USED)
                            rsp_reg <= '{status: RES_OK, found_key: key_rd,
                                         slot_index: 12'(pos_reg)};
                    end
                    else if (stat_rd == ST_USED && key_rd == req_reg.key)
                        rsp_reg <= '{status: RES_OK, found_key: 64'd0,
                                     slot_index: 12'(pos_reg)};
                end
            end
            default: lo_reg <= lo_reg;
        endcase
    end
endmodule
`default_nettype wire

[rtl/hrst_checker.sv]
// Port-level checker for the hashed resident set table, bound to the top level.
// Uses hrst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hrst_port_checker import hrst_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire rsp_t out_data
);
    `CHK_NEXT(out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `CHK_IMPL(busy_out, clk, rst_n, out_valid, in_stall)
    `CHK_IMPL(status_ok, clk, rst_n, out_valid,
              out_data.status == RES_OK || out_data.status == RES_MISS ||
              out_data.status == RES_FULL)
    `CHK_NEXT(one_beat, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind hashed_resident_set_table_top hrst_port_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
